[sv/bank_mapper_io_decoder_assert.svh]
// ----------------------------------------------------------------------------
// bank mapper io decoder assertion macros
// shared property forms used by the rtl modules of the decoder
// ----------------------------------------------------------------------------
`ifndef BANK_MAPPER_IO_DECODER_ASSERT_SVH
`define BANK_MAPPER_IO_DECODER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define BMIO_AST_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define BMIO_AST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[sv/bmio_pkg.sv]
// ----------------------------------------------------------------------------
// bmio_pkg
// types, codes and constants shared by the bank mapper io decoder
// ----------------------------------------------------------------------------
package bmio_pkg;

  // defaults for top level parameters
  localparam int LATCH_DEPTH_DEF = 256;
  localparam int MAX_BANKS_DEF   = 127;

  // field widths
  localparam int OP_W    = 2;
  localparam int ADDR_W  = 16;
  localparam int BYTE_W  = 8;
  localparam int CNT_W   = 7;
  localparam int TGT_W   = 3;
  localparam int PHYS_W  = 21;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 48;
  localparam int CFG_IDX_W   = 8;

  // access kinds
  typedef enum logic [OP_W-1:0] {
    OP_MEM_RD  = 2'd0,
    OP_MEM_WR  = 2'd1,
    OP_PORT_RD = 2'd2,
    OP_PORT_WR = 2'd3
  } op_t;

  // result targets
  typedef enum logic [TGT_W-1:0] {
    TGT_RAM   = 3'd0,
    TGT_BANK  = 3'd1,
    TGT_SCC   = 3'd2,
    TGT_FM    = 3'd3,
    TGT_SN    = 3'd4,
    TGT_AY    = 3'd5,
    TGT_LATCH = 3'd6,
    TGT_NONE  = 3'd7
  } tgt_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BANK_BASE  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BANK_COUNT = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EIGHT_K    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHIP_FLAGS = 8'd3;

  // memory map and port numbers
  localparam logic [ADDR_W-1:0] ADR_LOW_REG   = 16'h9000;
  localparam logic [ADDR_W-1:0] ADR_HIGH_REG  = 16'hB000;
  localparam logic [ADDR_W-1:0] ADR_SCC_FIRST = 16'h9800;
  localparam logic [ADDR_W-1:0] ADR_SCC_LAST  = 16'h988F;
  localparam logic [2:0]        WIN_LOW_TOP   = 3'b100;
  localparam logic [2:0]        WIN_HIGH_TOP  = 3'b101;
  localparam int                WIN_OFS_W     = 13;

  localparam logic [BYTE_W-1:0] PORT_IDLE    = 8'h01;
  localparam logic [BYTE_W-1:0] PORT_FM_A0   = 8'h7C;
  localparam logic [BYTE_W-1:0] PORT_FM_A1   = 8'h7D;
  localparam logic [BYTE_W-1:0] PORT_FM_B0   = 8'hC0;
  localparam logic [BYTE_W-1:0] PORT_FM_B1   = 8'hC1;
  localparam logic [BYTE_W-1:0] PORT_FM_C0   = 8'hF0;
  localparam logic [BYTE_W-1:0] PORT_FM_C1   = 8'hF1;
  localparam logic [BYTE_W-1:0] PORT_SN_0    = 8'h7E;
  localparam logic [BYTE_W-1:0] PORT_SN_1    = 8'h7F;
  localparam logic [BYTE_W-1:0] PORT_AY_0    = 8'hA0;
  localparam logic [BYTE_W-1:0] PORT_AY_1    = 8'hA1;
  localparam logic [BYTE_W-1:0] PORT_AY_2    = 8'hA2;
  localparam logic [BYTE_W-1:0] PORT_BANK16K = 8'hFE;

  // chip flag bits
  localparam int CF_FM      = 0;
  localparam int CF_SN      = 1;
  localparam int CF_STEREO  = 2;
  localparam int CF_SCC_OFF = 7;

  // configuration registers as seen by the decoder
  typedef struct packed {
    logic [BYTE_W-1:0] bank_base;
    logic [CNT_W-1:0]  bank_count;
    logic              eight_k;
    logic [BYTE_W-1:0] chip_flags;
  } cfg_t;

  // decoded access, before the latch read data joins it
  typedef struct packed {
    tgt_t              target;
    logic [PHYS_W-1:0] phys;
    logic [BYTE_W-1:0] wdata;
    logic              idle;
    logic              rd_sel;
  } res_t;

endpackage

[sv/bmio_latch.sv]
// ----------------------------------------------------------------------------
// bmio_latch
// port byte latch file: synchronous memory with per-entry valid bits
// ----------------------------------------------------------------------------
module bmio_latch #(
  parameter int LATCH_DEPTH = bmio_pkg::LATCH_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic                           rd_en,
  input  logic [$clog2(LATCH_DEPTH)-1:0] addr,
  input  logic [bmio_pkg::BYTE_W-1:0]    wdata,
  output logic [bmio_pkg::BYTE_W-1:0]    rdata
);

  logic [bmio_pkg::BYTE_W-1:0] mem [LATCH_DEPTH];
  logic [bmio_pkg::BYTE_W-1:0] mem_q_r;
  logic [LATCH_DEPTH-1:0]      vld_r;
  logic                        rd_vld_r;

  // storage array and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
    if (rd_en) begin
      mem_q_r <= mem[addr];
    end
  end

  // written marks, cleared together at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[addr];
      end
    end
  end

  // never written entries read as zero
  assign rdata = rd_vld_r ? mem_q_r : '0;

endmodule

[sv/bmio_decode.sv]
// ----------------------------------------------------------------------------
// bmio_decode
// access decoder with the two 8K window mapping registers
// ----------------------------------------------------------------------------
`include "bank_mapper_io_decoder_assert.svh"

module bmio_decode #(
  parameter int MAX_BANKS = bmio_pkg::MAX_BANKS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        acc,
  input  logic [bmio_pkg::OP_W-1:0]   op,
  input  logic [bmio_pkg::ADDR_W-1:0] address,
  input  logic [bmio_pkg::BYTE_W-1:0] data,
  input  bmio_pkg::cfg_t              cfg,
  output bmio_pkg::res_t              res
);

  localparam logic [bmio_pkg::CNT_W-1:0] MAX_CNT = bmio_pkg::CNT_W'(MAX_BANKS);

  logic                        lw_bank_r, lw_bank_nxt;
  logic                        hw_bank_r, hw_bank_nxt;
  logic [bmio_pkg::BYTE_W-1:0] lw_page_r, lw_page_nxt;
  logic [bmio_pkg::BYTE_W-1:0] hw_page_r, hw_page_nxt;
  logic                        idle_r, idle_nxt;

  logic [bmio_pkg::BYTE_W:0]   diff;
  logic [bmio_pkg::CNT_W-1:0]  cnt;
  logic                        bank_ok;
  logic [bmio_pkg::BYTE_W-1:0] port;
  logic                        scc_on;
  bmio_pkg::op_t               op_e;

  // bank number check: signed difference against the capped count
  assign diff    = {1'b0, data} - {1'b0, cfg.bank_base};
  assign cnt     = (cfg.bank_count < MAX_CNT) ? cfg.bank_count : MAX_CNT;
  assign bank_ok = !diff[bmio_pkg::BYTE_W] &&
                   (diff[bmio_pkg::BYTE_W-1:0] < {1'b0, cnt});

  assign port   = address[bmio_pkg::BYTE_W-1:0];
  assign scc_on = !cfg.chip_flags[bmio_pkg::CF_SCC_OFF] &&
                  (cfg.chip_flags[bmio_pkg::CF_STEREO:bmio_pkg::CF_SN] != 2'b10);
  assign op_e   = bmio_pkg::op_t'(op);

  // decode and mapping register updates
  always_comb begin
    res         = '0;
    res.target  = bmio_pkg::TGT_NONE;
    lw_bank_nxt = lw_bank_r;
    hw_bank_nxt = hw_bank_r;
    lw_page_nxt = lw_page_r;
    hw_page_nxt = hw_page_r;
    idle_nxt    = idle_r;
    case (op_e)
      bmio_pkg::OP_MEM_RD: begin
        res.target = bmio_pkg::TGT_RAM;
        res.phys   = bmio_pkg::PHYS_W'(address);
        if (address[15:13] == bmio_pkg::WIN_LOW_TOP && lw_bank_r) begin
          res.target = bmio_pkg::TGT_BANK;
          res.phys   = {lw_page_r, address[bmio_pkg::WIN_OFS_W-1:0]};
        end else if (address[15:13] == bmio_pkg::WIN_HIGH_TOP && hw_bank_r) begin
          res.target = bmio_pkg::TGT_BANK;
          res.phys   = {hw_page_r, address[bmio_pkg::WIN_OFS_W-1:0]};
        end
      end
      bmio_pkg::OP_MEM_WR: begin
        res.wdata = data;
        if (cfg.eight_k && address == bmio_pkg::ADR_LOW_REG) begin
          lw_bank_nxt = bank_ok;
          if (bank_ok) lw_page_nxt = diff[bmio_pkg::BYTE_W-1:0];
        end else if (cfg.eight_k && address == bmio_pkg::ADR_HIGH_REG) begin
          hw_bank_nxt = bank_ok;
          if (bank_ok) hw_page_nxt = diff[bmio_pkg::BYTE_W-1:0];
        end else if (scc_on && address >= bmio_pkg::ADR_SCC_FIRST &&
                     address <= bmio_pkg::ADR_SCC_LAST) begin
          res.target = bmio_pkg::TGT_SCC;
          res.phys   = bmio_pkg::PHYS_W'(address - bmio_pkg::ADR_SCC_FIRST);
        end else begin
          res.target = bmio_pkg::TGT_RAM;
          res.phys   = bmio_pkg::PHYS_W'(address);
        end
      end
      bmio_pkg::OP_PORT_RD: begin
        if (port == bmio_pkg::PORT_IDLE) begin
          idle_nxt = 1'b1;
          res.idle = 1'b1;
        end else if ((port == bmio_pkg::PORT_AY_0 || port == bmio_pkg::PORT_AY_1 ||
                      port == bmio_pkg::PORT_AY_2) &&
                     !cfg.chip_flags[bmio_pkg::CF_SN]) begin
          res.target = bmio_pkg::TGT_AY;
          res.phys   = bmio_pkg::PHYS_W'(port[1:0]);
        end else begin
          res.target = bmio_pkg::TGT_LATCH;
          res.phys   = bmio_pkg::PHYS_W'(port);
          res.rd_sel = 1'b1;
        end
      end
      bmio_pkg::OP_PORT_WR: begin
        res.wdata  = data;
        res.target = bmio_pkg::TGT_LATCH;
        res.phys   = bmio_pkg::PHYS_W'(port);
        case (port)
          bmio_pkg::PORT_FM_A0, bmio_pkg::PORT_FM_A1, bmio_pkg::PORT_FM_B0,
          bmio_pkg::PORT_FM_B1, bmio_pkg::PORT_FM_C0, bmio_pkg::PORT_FM_C1: begin
            if (cfg.chip_flags[bmio_pkg::CF_FM]) begin
              res.target = bmio_pkg::TGT_FM;
              res.phys   = bmio_pkg::PHYS_W'(port[0]);
            end
          end
          bmio_pkg::PORT_SN_0, bmio_pkg::PORT_SN_1: begin
            if (cfg.chip_flags[bmio_pkg::CF_SN]) begin
              res.target = bmio_pkg::TGT_SN;
              res.phys   = '0;
            end
          end
          bmio_pkg::PORT_AY_0, bmio_pkg::PORT_AY_1: begin
            if (!cfg.chip_flags[bmio_pkg::CF_SN]) begin
              res.target = bmio_pkg::TGT_AY;
              res.phys   = bmio_pkg::PHYS_W'(port[0]);
            end
          end
          bmio_pkg::PORT_BANK16K: begin
            // 16K bank: both windows, even and odd page
            lw_bank_nxt = bank_ok;
            hw_bank_nxt = bank_ok;
            if (bank_ok) begin
              lw_page_nxt = {diff[bmio_pkg::BYTE_W-2:0], 1'b0};
              hw_page_nxt = {diff[bmio_pkg::BYTE_W-2:0], 1'b1};
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // mapping state, updated only when an access is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_bank_r <= 1'b0;
      hw_bank_r <= 1'b0;
      lw_page_r <= '0;
      hw_page_r <= '0;
      idle_r    <= 1'b0;
    end else if (acc) begin
      lw_bank_r <= lw_bank_nxt;
      hw_bank_r <= hw_bank_nxt;
      lw_page_r <= lw_page_nxt;
      hw_page_r <= hw_page_nxt;
      idle_r    <= idle_nxt;
    end
  end

  // checks
  `BMIO_AST_NXT(a_idle_sticky, acc && res.idle, idle_r, "idle flag not set after idle read")
  `BMIO_AST_IMP(a_latch_rd_only_port_rd, res.rd_sel, op_e == bmio_pkg::OP_PORT_RD,
                "latch read selected on a non port read")
  `BMIO_AST_NXT(a_no_map_change_idle, !acc,
                $stable(lw_bank_r) && $stable(hw_bank_r) && $stable(lw_page_r),
                "window mapping changed without an access")

endmodule

[sv/bank_mapper_io_decoder.sv]
// ----------------------------------------------------------------------------
// bank_mapper_io_decoder
// cpu bus access decoder: bank window mapping, sound chip routing, port latch
// ----------------------------------------------------------------------------
// Use: each word on the in_ stream is one cpu bus access (op, address, data);
// each word on the out_ stream is its decoded result (target, physical
// address, read data, write data, idle flag), one result per access, in order.
// The cfg_ channel writes the four setup registers; it is always ready and is
// meant to be written while no access is in flight.
// A taken access waits in stage 1 for the registered read of the port latch
// memory, then moves into the output register, which offers the result.
// Throughput: one access per cycle while in_tready is high; the latch memory
// has one port used once per access, and reads and writes happen at the same
// point, so back to back accesses to one port need no forwarding.
// Stall: the output register and the stage before it hold two results;
// in_tready drops only when both are full and out_tready is low.
// Reset: rst_n (synchronous, active low) clears the valid flags, setup registers,
// window mappings, the idle flag and the latch valid bits, so every latch byte reads as zero.
// ----------------------------------------------------------------------------
`include "bank_mapper_io_decoder_assert.svh"

module bank_mapper_io_decoder #(
  parameter int LATCH_DEPTH = bmio_pkg::LATCH_DEPTH_DEF,
  parameter int MAX_BANKS   = bmio_pkg::MAX_BANKS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // access stream; tdata: op[1:0], address[17:2], data[25:18], zero[31:26]
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [bmio_pkg::IN_TDATA_W-1:0]  in_tdata,
  // result stream; tdata: target[2:0], physical_address[23:3],
  // read_data[31:24], write_data[39:32], idle_seen[40], zero[47:41]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [bmio_pkg::OUT_TDATA_W-1:0] out_tdata,
  // setup register writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bmio_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bmio_pkg::BYTE_W-1:0]      cfg_wdata
);

  localparam int AW = $clog2(LATCH_DEPTH);

  bmio_pkg::cfg_t              cfg_r;
  bmio_pkg::res_t              dec_res;
  bmio_pkg::res_t              s1_r;
  logic                        s1_valid_r;
  logic                        out_valid_r;
  bmio_pkg::res_t              out_res_r;
  logic [bmio_pkg::BYTE_W-1:0] out_rdata_r;
  logic [bmio_pkg::BYTE_W-1:0] latch_rdata;
  logic                        in_acc;
  logic                        s1_adv;
  logic                        out_free;
  logic                        latch_wr;

  logic [bmio_pkg::OP_W-1:0]   in_op;
  logic [bmio_pkg::ADDR_W-1:0] in_address;
  logic [bmio_pkg::BYTE_W-1:0] in_data;

  // input word fields
  assign in_op      = in_tdata[1:0];
  assign in_address = in_tdata[17:2];
  assign in_data    = in_tdata[25:18];

  // handshakes
  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign latch_wr  = in_acc && (bmio_pkg::op_t'(in_op) == bmio_pkg::OP_PORT_WR);

  // setup registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bmio_pkg::REG_BANK_BASE:  cfg_r.bank_base  <= cfg_wdata;
        bmio_pkg::REG_BANK_COUNT: cfg_r.bank_count <= cfg_wdata[bmio_pkg::CNT_W-1:0];
        bmio_pkg::REG_EIGHT_K:    cfg_r.eight_k    <= cfg_wdata[0];
        bmio_pkg::REG_CHIP_FLAGS: cfg_r.chip_flags <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  bmio_decode #(
    .MAX_BANKS (MAX_BANKS)
  ) u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (in_acc),
    .op      (in_op),
    .address (in_address),
    .data    (in_data),
    .cfg     (cfg_r),
    .res     (dec_res)
  );

  bmio_latch #(
    .LATCH_DEPTH (LATCH_DEPTH)
  ) u_latch (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (latch_wr),
    .rd_en (in_acc),
    .addr  (in_address[AW-1:0]),
    .wdata (in_data),
    .rdata (latch_rdata)
  );

  // stage 1: decoded access waits for the latch read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= dec_res;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r   <= s1_r;
      out_rdata_r <= s1_r.rd_sel ? latch_rdata : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_res_r.idle, out_res_r.wdata, out_rdata_r,
                       out_res_r.phys, out_res_r.target};

  // checks
  `BMIO_AST_IMP(a_stall_only_when_full, !in_tready, s1_valid_r && out_valid_r,
                "input stalled with a free result slot")
  `BMIO_AST_IMP(a_rdata_only_latch, out_valid_r && out_rdata_r != '0,
                out_res_r.target == bmio_pkg::TGT_LATCH, "read data on a non latch result")
  `BMIO_AST_NXT(a_s1_held, s1_valid_r && !s1_adv, s1_valid_r && $stable(s1_r),
                "pending result lost while stalled")

endmodule
